/* hw/rtl/dnts_pkg.sv */
package dnts_pkg;

  localparam int LEN_BITS = 16;
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  typedef enum logic [17:0] {
    PH_WS     = 18'h00001,
    PH_SIGN   = 18'h00002,
    PH_I1     = 18'h00004,
    PH_I2     = 18'h00008,
    PH_INF3   = 18'h00010,
    PH_INF4   = 18'h00020,
    PH_INF5   = 18'h00040,
    PH_INF6   = 18'h00080,
    PH_INF7   = 18'h00100,
    PH_N1     = 18'h00200,
    PH_N2     = 18'h00400,
    PH_NAN3   = 18'h00800,
    PH_NANTL  = 18'h01000,
    PH_DIGITS = 18'h02000,
    PH_EXP1   = 18'h04000,
    PH_EXP2   = 18'h08000,
    PH_EXPD   = 18'h10000,
    PH_DONE   = 18'h20000
  } phase_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_FIN  = 2'd1;
  localparam logic [1:0] KIND_INF  = 2'd2;
  localparam logic [1:0] KIND_NAN  = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_Y      = 8'h79;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_A      = 8'h61;

  typedef struct packed {
    phase_t              phase;
    logic [LEN_BITS-1:0] pos;
    logic [LEN_BITS-1:0] end_pos;
    logic [1:0]          kind;
    logic                dot;
  } scan_state_t;

  localparam scan_state_t SCAN_RST = '{
    phase:   PH_WS,
    pos:     '0,
    end_pos: '0,
    kind:    KIND_NONE,
    dot:     1'b0
  };

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // lower-case letter or its upper-case twin
  function automatic logic is_ltr(input logic [7:0] c, input logic [7:0] lower);
    return (c == lower) || (c == (lower - 8'h20));
  endfunction

endpackage

/* hw/rtl/dnts_step.sv */
module dnts_step
  import dnts_pkg::*;
(
  input  scan_state_t cur,
  input  logic [7:0]  char_byte,
  output scan_state_t nxt
);

  logic [LEN_BITS-1:0] end_here;
  logic                sat;
  phase_t              body_phase;
  logic                body_acc;
  logic                body_dot;

  assign sat      = (cur.pos == LEN_MAX);
  assign end_here = sat ? LEN_MAX : cur.pos + 1'b1;

  // first character of the number body
  always_comb begin
    body_acc = 1'b0;
    body_dot = 1'b0;
    if (is_ltr(char_byte, CH_I)) begin
      body_phase = PH_I1;
    end else if (is_ltr(char_byte, CH_N)) begin
      body_phase = PH_N1;
    end else if (is_dig(char_byte)) begin
      body_phase = PH_DIGITS;
      body_acc   = 1'b1;
    end else if (char_byte == CH_DOT) begin
      body_phase = PH_DIGITS;
      body_acc   = 1'b1;
      body_dot   = 1'b1;
    end else begin
      body_phase = PH_DONE;
    end
  end

  always_comb begin
    logic       acc;
    logic [1:0] acc_kind;
    nxt      = cur;
    acc      = 1'b0;
    acc_kind = KIND_FIN;
    nxt.pos  = end_here;
    unique case (cur.phase)
      PH_WS: begin
        if (!is_ws(char_byte)) begin
          if (char_byte == CH_PLUS || char_byte == CH_MINUS) begin
            nxt.phase = PH_SIGN;
          end else begin
            nxt.phase = body_phase;
            acc       = body_acc;
            nxt.dot   = cur.dot | body_dot;
          end
        end
      end
      PH_SIGN: begin
        nxt.phase = body_phase;
        acc       = body_acc;
        nxt.dot   = cur.dot | body_dot;
      end
      PH_I1:   nxt.phase = is_ltr(char_byte, CH_N) ? PH_I2 : PH_DONE;
      PH_I2: begin
        if (is_ltr(char_byte, CH_F)) begin
          acc       = 1'b1;
          acc_kind  = KIND_INF;
          nxt.phase = PH_INF3;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_INF3: nxt.phase = is_ltr(char_byte, CH_I) ? PH_INF4 : PH_DONE;
      PH_INF4: nxt.phase = is_ltr(char_byte, CH_N) ? PH_INF5 : PH_DONE;
      PH_INF5: nxt.phase = is_ltr(char_byte, CH_I) ? PH_INF6 : PH_DONE;
      PH_INF6: nxt.phase = is_ltr(char_byte, CH_T) ? PH_INF7 : PH_DONE;
      PH_INF7: begin
        acc       = is_ltr(char_byte, CH_Y);
        acc_kind  = KIND_INF;
        nxt.phase = PH_DONE;
      end
      PH_N1:   nxt.phase = is_ltr(char_byte, CH_A) ? PH_N2 : PH_DONE;
      PH_N2: begin
        if (is_ltr(char_byte, CH_N)) begin
          acc       = 1'b1;
          acc_kind  = KIND_NAN;
          nxt.phase = PH_NAN3;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_NAN3: begin
        if (char_byte == CH_LPAREN) begin
          acc       = 1'b1;
          acc_kind  = KIND_NAN;
          nxt.phase = PH_NANTL;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_NANTL: begin
        // unclosed tail swallows everything up to the terminator
        acc      = 1'b1;
        acc_kind = KIND_NAN;
        if (char_byte == CH_RPAREN) nxt.phase = PH_DONE;
      end
      PH_DIGITS: begin
        if (is_dig(char_byte)) begin
          acc = 1'b1;
        end else if (char_byte == CH_DOT && !cur.dot) begin
          acc     = 1'b1;
          nxt.dot = 1'b1;
        end else if (is_ltr(char_byte, CH_E)) begin
          nxt.phase = PH_EXP1;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_EXP1: begin
        if (char_byte == CH_PLUS || char_byte == CH_MINUS) begin
          nxt.phase = PH_EXP2;
        end else if (is_dig(char_byte)) begin
          acc       = 1'b1;
          nxt.phase = PH_EXPD;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_EXP2, PH_EXPD: begin
        if (is_dig(char_byte)) begin
          acc       = 1'b1;
          nxt.phase = PH_EXPD;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      default: nxt.phase = PH_DONE;
    endcase
    if (acc) begin
      nxt.end_pos = end_here;
      nxt.kind    = acc_kind;
    end
  end

endmodule

/* hw/rtl/decimal_number_token_scanner.sv */
// Decimal number token scanner.
// Input channel: one character per transaction on in_char_byte (in_valid /
// in_stall). A zero byte terminates the string. Output channel: one
// transaction per string, issued for the zero byte, carrying the number of
// leading characters that form a number (whitespace and sign included,
// saturating at the all-ones value) and its kind: none, finite, inf, nan.
// Throughput: one character per cycle, sustained, except while a zero byte
// waits for the result register. The character goes into an input register;
// a scanner step then updates the phase state and, for a zero byte, loads the
// result register, from which out_valid is driven.
// A stalled result stays in the output register while characters of the
// next string keep flowing; only the next zero byte waits, raising in_stall,
// until the result register frees up.
// Reset (rst_n low, synchronous) drops both valids and returns the scanner
// to the leading whitespace phase with empty length and kind.
module decimal_number_token_scanner
  import dnts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_char_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LEN_BITS-1:0] out_consumed_len,
  output logic [1:0]          out_token_kind
);

  logic                s1_valid_r;
  logic [7:0]          s1_char_r;
  scan_state_t         state_r;
  scan_state_t         state_nxt;
  logic                out_valid_r;
  logic [LEN_BITS-1:0] out_len_r;
  logic [1:0]          out_kind_r;
  logic                out_free;
  logic                s1_term;
  logic                s1_go;

  dnts_step u_step (
    .cur       (state_r),
    .char_byte (s1_char_r),
    .nxt       (state_nxt)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_term  = (s1_char_r == CH_NUL);
  assign s1_go    = s1_valid_r && (!s1_term || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_char_r <= in_char_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SCAN_RST;
    end else if (s1_go) begin
      state_r <= s1_term ? SCAN_RST : state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_term) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_term) begin
      out_len_r  <= state_r.end_pos;
      out_kind_r <= state_r.kind;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_consumed_len = out_len_r;
  assign out_token_kind   = out_kind_r;

`ifndef SYNTHESIS
  a_none_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.kind == KIND_NONE |-> state_r.end_pos == '0)
    else $error("token end set without a token kind");

  a_end_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.end_pos <= state_r.pos)
    else $error("token end beyond characters seen");

  a_out_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_NONE |-> out_len_r == '0)
    else $error("result with no number but nonzero length");

  a_stall_only_term: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_term && out_valid_r)
    else $error("input stalled without a blocked terminator");

  a_term_resets: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_term |=> state_r == SCAN_RST && out_valid_r)
    else $error("terminator did not reset scanner and post result");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top
  import dnts_pkg::*;
;

  typedef struct {
    logic [LEN_BITS-1:0] len;
    logic [1:0]          kind;
  } token_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_char_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [LEN_BITS-1:0] out_consumed_len;
  logic [1:0]          out_token_kind;

  logic [7:0] pending_chars[$];
  token_t     expected_tokens[$];
  token_t     head_tok;
  int         error_count = 0;
  int         gap_left = 0;
  int         in_quiet = 0;
  int         stall_left = 0;
  int         out_quiet = 0;

  // scanner state as predicted by the testbench
  phase_t              cur_phase = PH_WS;
  logic [LEN_BITS-1:0] char_count = '0;
  logic [LEN_BITS-1:0] tok_end = '0;
  logic [1:0]          tok_kind = KIND_NONE;
  logic                dot_taken = 1'b0;

  decimal_number_token_scanner DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_byte    (in_char_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_consumed_len(out_consumed_len),
    .out_token_kind  (out_token_kind)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_decimal(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic letter_eq(logic [7:0] c, logic [7:0] lower);
    return (c == lower) || (c == (lower ^ 8'h20));
  endfunction

  function automatic void clear_scan();
    cur_phase  = PH_WS;
    char_count = '0;
    tok_end    = '0;
    tok_kind   = KIND_NONE;
    dot_taken  = 1'b0;
  endfunction

  // token now ends after the current character
  function automatic void mark_token(logic [1:0] k);
    tok_end  = (char_count == LEN_MAX) ? LEN_MAX : char_count + 1'b1;
    tok_kind = k;
  endfunction

  function automatic void next_if(logic [7:0] c, logic [7:0] lower, phase_t nxt);
    cur_phase = letter_eq(c, lower) ? nxt : PH_DONE;
  endfunction

  function automatic void open_body(logic [7:0] c);
    if (letter_eq(c, CH_I)) begin
      cur_phase = PH_I1;
    end else if (letter_eq(c, CH_N)) begin
      cur_phase = PH_N1;
    end else if (is_decimal(c)) begin
      mark_token(KIND_FIN);
      cur_phase = PH_DIGITS;
    end else if (c == CH_DOT) begin
      dot_taken = 1'b1;
      mark_token(KIND_FIN);
      cur_phase = PH_DIGITS;
    end else begin
      cur_phase = PH_DONE;
    end
  endfunction

  function automatic void take_char(logic [7:0] c);
    token_t t;
    if (c == CH_NUL) begin
      t.len  = tok_end;
      t.kind = tok_kind;
      expected_tokens.push_back(t);
      clear_scan();
      return;
    end
    case (cur_phase)
      PH_WS: begin
        if (!is_blank(c)) begin
          if (c == CH_PLUS || c == CH_MINUS) cur_phase = PH_SIGN;
          else open_body(c);
        end
      end
      PH_SIGN: open_body(c);
      PH_I1:   next_if(c, CH_N, PH_I2);
      PH_I2: begin
        if (letter_eq(c, CH_F)) begin
          mark_token(KIND_INF);
          cur_phase = PH_INF3;
        end else begin
          cur_phase = PH_DONE;
        end
      end
      PH_INF3: next_if(c, CH_I, PH_INF4);
      PH_INF4: next_if(c, CH_N, PH_INF5);
      PH_INF5: next_if(c, CH_I, PH_INF6);
      PH_INF6: next_if(c, CH_T, PH_INF7);
      PH_INF7: begin
        if (letter_eq(c, CH_Y)) mark_token(KIND_INF);
        cur_phase = PH_DONE;
      end
      PH_N1: next_if(c, CH_A, PH_N2);
      PH_N2: begin
        if (letter_eq(c, CH_N)) begin
          mark_token(KIND_NAN);
          cur_phase = PH_NAN3;
        end else begin
          cur_phase = PH_DONE;
        end
      end
      PH_NAN3: begin
        if (c == CH_LPAREN) begin
          mark_token(KIND_NAN);
          cur_phase = PH_NANTL;
        end else begin
          cur_phase = PH_DONE;
        end
      end
      PH_NANTL: begin
        // open tail swallows everything up to ')' or end of string
        mark_token(KIND_NAN);
        if (c == CH_RPAREN) cur_phase = PH_DONE;
      end
      PH_DIGITS: begin
        if (is_decimal(c)) begin
          mark_token(KIND_FIN);
        end else if (c == CH_DOT && !dot_taken) begin
          dot_taken = 1'b1;
          mark_token(KIND_FIN);
        end else if (letter_eq(c, CH_E)) begin
          cur_phase = PH_EXP1;
        end else begin
          cur_phase = PH_DONE;
        end
      end
      PH_EXP1: begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          cur_phase = PH_EXP2;
        end else if (is_decimal(c)) begin
          mark_token(KIND_FIN);
          cur_phase = PH_EXPD;
        end else begin
          cur_phase = PH_DONE;
        end
      end
      PH_EXP2, PH_EXPD: begin
        if (is_decimal(c)) begin
          mark_token(KIND_FIN);
          cur_phase = PH_EXPD;
        end else begin
          cur_phase = PH_DONE;
        end
      end
      default: cur_phase = PH_DONE;
    endcase
    if (char_count != LEN_MAX) char_count = char_count + 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // mostly no gap, some short, a few long; occasional stretches with none
  function automatic int next_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) quiet = $urandom_range(20, 80);
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
  endfunction

  function automatic logic [7:0] blank_char();
    int n;
    n = $urandom_range(0, 5);
    return (n == 5) ? 8'h20 : 8'(8'h09 + n);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    return $urandom_range(0, 1) ? (c ^ 8'h20) : c;
  endfunction

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(1, 255));
  endfunction

  // one string plus its terminator; mostly well-formed numbers, some noise
  function automatic void add_random_string();
    logic [7:0] body[$];
    string      word_text;
    int         n;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(0, 8)) body.push_back(any_char());
    end else begin
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) body.push_back(blank_char());
      case ($urandom_range(0, 3))
        0:       body.push_back(CH_PLUS);
        1:       body.push_back(CH_MINUS);
        default: ;
      endcase
      case ($urandom_range(0, 5))
        2, 3: begin
          word_text = "infinity";
          n = $urandom_range(0, 1) ? 8 : ($urandom_range(0, 1) ? 3 : $urandom_range(1, 7));
          for (int i = 0; i < n; i++) body.push_back(flip_case(word_text[i]));
        end
        4: begin
          word_text = "nan";
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 3;
          for (int i = 0; i < n; i++) body.push_back(flip_case(word_text[i]));
          if ($urandom_range(0, 1)) begin
            body.push_back(CH_LPAREN);
            repeat ($urandom_range(0, 4)) body.push_back(any_char());
            if ($urandom_range(0, 3) != 0) body.push_back(CH_RPAREN);
          end
        end
        default: begin
          repeat ($urandom_range(0, 4)) body.push_back(rand_digit());
          if ($urandom_range(0, 1)) begin
            body.push_back(CH_DOT);
            repeat ($urandom_range(0, 3)) body.push_back(rand_digit());
            if ($urandom_range(0, 5) == 0) body.push_back(CH_DOT);
          end
          if ($urandom_range(0, 2) == 0) begin
            body.push_back(flip_case(CH_E));
            case ($urandom_range(0, 2))
              0:       body.push_back(CH_PLUS);
              1:       body.push_back(CH_MINUS);
              default: ;
            endcase
            repeat ($urandom_range(0, 3)) body.push_back(rand_digit());
          end
        end
      endcase
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) body.push_back(any_char());
      // occasionally break the sequence
      if (body.size() > 0 && $urandom_range(0, 9) == 0)
        body[$urandom_range(0, body.size() - 1)] = any_char();
    end
    foreach (body[k]) pending_chars.push_back(body[k]);
    pending_chars.push_back(CH_NUL);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) take_char(in_char_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          in_valid     <= 1'b1;
          in_char_byte <= pending_chars.pop_front();
          gap_left = next_gap(in_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          flag_error($sformatf("unexpected transaction: len=%0d kind=%0d",
                               out_consumed_len, out_token_kind));
        end else begin
          head_tok = expected_tokens.pop_front();
          if (out_consumed_len !== head_tok.len || out_token_kind !== head_tok.kind)
            flag_error($sformatf("token mismatch: exp len=%0d kind=%0d, got len=%0d kind=%0d",
                                 head_tok.len, head_tok.kind,
                                 out_consumed_len, out_token_kind));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = next_gap(out_quiet);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // directed: empty string, lone dot, bare exponent, partial inf,
    // unclosed nan tail with 0xFF, second dot
    pending_chars.push_back(CH_NUL);
    add_text(".");
    pending_chars.push_back(CH_NUL);
    add_text("5e+");
    pending_chars.push_back(CH_NUL);
    add_text("inFx");
    pending_chars.push_back(CH_NUL);
    add_text("\tnAn(");
    pending_chars.push_back(8'hFF);
    pending_chars.push_back(CH_NUL);
    add_text("+9..");
    pending_chars.push_back(CH_NUL);

    while (pending_chars.size() < 1750) add_random_string();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_chars.size() != 0 || in_valid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
